// ----- rtl/rmte_pkg.sv -----
// shared types, constants and helper functions for the rotation matrix to euler unit
`timescale 1ns / 1ps
`default_nettype none
package rmte_pkg;

  localparam int IN_W       = 18;
  localparam int OUT_W      = 19;
  localparam int THR_W      = 17;
  localparam int SQ_W       = 36;
  localparam int ROOT_W     = 18;
  localparam int XW         = 22;
  localparam int ZW         = 28;
  localparam int TABLE_LEN  = 24;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRAC_BITS_DEF     = 16;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
  localparam logic [32:0]      PI_Q30    = 33'd3373259426;

  localparam logic signed [ZW-1:0] OUT_MAX = ZW'(262143);
  localparam logic signed [ZW-1:0] OUT_MIN = -ZW'(262144);

  typedef logic [31:0] q30_tab_t [TABLE_LEN];
  localparam q30_tab_t ATAN_Q30 = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // matrix elements riding alongside the square root
  typedef struct packed {
    logic signed [IN_W-1:0] r00;
    logic signed [IN_W-1:0] r10;
    logic signed [IN_W-1:0] r20;
    logic signed [IN_W-1:0] r21;
    logic signed [IN_W-1:0] r22;
    logic signed [IN_W-1:0] r11;
    logic signed [IN_W-1:0] r12;
  } mat_t;

  // one cordic lane between cells
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cord_t;

  // q30 constant rounded half up to fb fraction bits
  function automatic logic [ZW-1:0] from_q30(input logic [32:0] v, input int fb);
    logic [32:0] s;
    s = (v + (33'd1 << (29 - fb))) >> (30 - fb);
    return s[ZW-1:0];
  endfunction

  function automatic logic [ZW-1:0] atan_fix(input int idx, input int fb);
    return from_q30({1'b0, ATAN_Q30[idx]}, fb);
  endfunction

  // move the vector into the right half plane before the rotations
  function automatic cord_t prerot(input logic signed [XW-1:0] y,
                                   input logic signed [XW-1:0] x,
                                   input logic signed [ZW-1:0] pi);
    cord_t c;
    c.zero = (x == '0) && (y == '0);
    if (x[XW-1]) begin
      c.x = -x;
      c.y = -y;
      c.z = y[XW-1] ? -pi : pi;
    end else begin
      c.x = x;
      c.y = y;
      c.z = '0;
    end
    return c;
  endfunction

  // clamp to +-pi, then to the output range; zero for a zero vector or when forced
  function automatic logic signed [OUT_W-1:0] sat_angle(input cord_t c, input logic forced_zero,
                                                        input logic signed [ZW-1:0] pi);
    logic signed [ZW-1:0] z;
    z = c.z;
    if (z > pi)      z = pi;
    if (z < -pi)     z = -pi;
    if (z > OUT_MAX) z = OUT_MAX;
    if (z < OUT_MIN) z = OUT_MIN;
    if (c.zero || forced_zero) z = '0;
    return z[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rmte_sqrt_cell.sv -----
// one result bit of the digit by digit square root
`timescale 1ns / 1ps
`default_nettype none
module rmte_sqrt_cell #(
  parameter int BIT = 0
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [rmte_pkg::SQ_W-1:0]      rem_in,
  input  wire logic [rmte_pkg::ROOT_W-1:0]    root_in,
  output logic      [rmte_pkg::SQ_W-1:0]      rem_out,
  output logic      [rmte_pkg::ROOT_W-1:0]    root_out
);

  logic [rmte_pkg::SQ_W:0]     trial;
  logic [rmte_pkg::SQ_W-1:0]   rem_next;
  logic [rmte_pkg::ROOT_W-1:0] root_next;

  // trial = 2*root*2^bit + 4^bit
  always_comb begin
    trial = ({{(rmte_pkg::SQ_W + 1 - rmte_pkg::ROOT_W){1'b0}}, root_in} << (BIT + 1))
          + ((rmte_pkg::SQ_W + 1)'(1) << (2 * BIT));
    if ({1'b0, rem_in} >= trial) begin
      rem_next  = rem_in - trial[rmte_pkg::SQ_W-1:0];
      root_next = root_in | (rmte_pkg::ROOT_W'(1) << BIT);
    end else begin
      rem_next  = rem_in;
      root_next = root_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_next;
      root_out <= root_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rmte_cordic_cell.sv -----
// one vectoring rotation of a cordic lane
`timescale 1ns / 1ps
`default_nettype none
module rmte_cordic_cell #(
  parameter int STAGE     = 0,
  parameter int FRAC_BITS = rmte_pkg::FRAC_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire rmte_pkg::cord_t c_in,
  output rmte_pkg::cord_t      c_out
);

  localparam logic signed [rmte_pkg::ZW-1:0] ATAN = rmte_pkg::atan_fix(STAGE, FRAC_BITS);

  rmte_pkg::cord_t            c_next;
  logic signed [rmte_pkg::XW-1:0] dx;
  logic signed [rmte_pkg::XW-1:0] dy;

  always_comb begin
    dx = c_in.y >>> STAGE;
    dy = c_in.x >>> STAGE;
    c_next.zero = c_in.zero;
    if (!c_in.y[rmte_pkg::XW-1]) begin
      c_next.x = c_in.x + dx;
      c_next.y = c_in.y - dy;
      c_next.z = c_in.z + ATAN;
    end else begin
      c_next.x = c_in.x - dx;
      c_next.y = c_in.y + dy;
      c_next.z = c_in.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_out <= c_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rotation_matrix_to_euler_unit.sv -----
// top level: rotation matrix to zyx euler angles through sqrt and cordic cell chains
`timescale 1ns / 1ps
`default_nettype none
// channel   | handshake                  | payload
// ----------+----------------------------+----------------------------------------
// input     | in_valid / in_ready        | r00 r10 r20 r21 r22 r11 r12 (q2.16)
// output    | out_valid / out_ready      | roll_x pitch_y yaw_z (q3.16), gimbal_lock
// config    | cfg_wr_en                  | cfg_wr_data (singular_threshold)
//
// one beat accepted per cycle while the chain is not held; the stages in order are
// (square, 18 root cells, lane setup, CORDIC_STAGES rotation cells, output)
// the whole chain advances together; it holds whenever the output beat waits,
// bubbles ahead of it included, so in_ready = !out_valid || out_ready
// reset clears the valid bits and sets the threshold to 1
module rotation_matrix_to_euler_unit #(
  parameter int CORDIC_STAGES = rmte_pkg::CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = rmte_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [rmte_pkg::IN_W-1:0]     r00,
  input  wire logic signed [rmte_pkg::IN_W-1:0]     r10,
  input  wire logic signed [rmte_pkg::IN_W-1:0]     r20,
  input  wire logic signed [rmte_pkg::IN_W-1:0]     r21,
  input  wire logic signed [rmte_pkg::IN_W-1:0]     r22,
  input  wire logic signed [rmte_pkg::IN_W-1:0]     r11,
  input  wire logic signed [rmte_pkg::IN_W-1:0]     r12,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [rmte_pkg::OUT_W-1:0]         roll_x,
  output logic signed [rmte_pkg::OUT_W-1:0]         pitch_y,
  output logic signed [rmte_pkg::OUT_W-1:0]         yaw_z,
  output logic                                      gimbal_lock,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [rmte_pkg::THR_W-1:0]           cfg_wr_data
);

  localparam int NBITS = rmte_pkg::ROOT_W;
  localparam int DEPTH = NBITS + CORDIC_STAGES + 3;
  localparam logic signed [rmte_pkg::ZW-1:0] PI = rmte_pkg::from_q30(rmte_pkg::PI_Q30, FRAC_BITS);

  logic                          en;
  logic [DEPTH-1:0]              vld;
  logic [rmte_pkg::THR_W-1:0]    thr;

  // square root chain
  logic [rmte_pkg::SQ_W-1:0]     rem_s  [NBITS+1];
  logic [rmte_pkg::ROOT_W-1:0]   root_s [NBITS+1];
  rmte_pkg::mat_t                pl     [NBITS+1];

  // cordic chain: lane 0 roll, lane 1 pitch, lane 2 yaw
  rmte_pkg::cord_t               cs [CORDIC_STAGES+1][3];
  logic                          lk [CORDIC_STAGES+1];

  logic signed [2*rmte_pkg::IN_W-1:0] sq0;
  logic signed [2*rmte_pkg::IN_W-1:0] sq1;
  logic                               lock_c;
  logic signed [rmte_pkg::XW-1:0]     roll_y;
  logic signed [rmte_pkg::XW-1:0]     roll_x_in;

  assign en        = !vld[DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      thr <= rmte_pkg::THR_RESET;
    end else begin
      if (en) begin
        vld <= {vld[DEPTH-2:0], in_valid};
      end
      if (cfg_wr_en) begin
        thr <= cfg_wr_data;
      end
    end
  end

  // squares and sum
  assign sq0 = r00 * r00;
  assign sq1 = r10 * r10;
  assign root_s[0] = '0;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= rmte_pkg::SQ_W'(sq0) + rmte_pkg::SQ_W'(sq1);
      pl[0]    <= '{r00: r00, r10: r10, r20: r20, r21: r21, r22: r22, r11: r11, r12: r12};
    end
  end

  for (genvar k = 0; k < NBITS; k++) begin : g_sqrt
    rmte_sqrt_cell #(.BIT(NBITS - 1 - k)) u_cell (
      .clk      (clk),
      .en       (en),
      .rem_in   (rem_s[k]),
      .root_in  (root_s[k]),
      .rem_out  (rem_s[k+1]),
      .root_out (root_s[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        pl[k+1] <= pl[k];
      end
    end
  end

  // lane setup: lock decision picks the roll operands
  always_comb begin
    lock_c = root_s[NBITS] < {1'b0, thr};
    if (lock_c) begin
      roll_y    = -rmte_pkg::XW'(pl[NBITS].r12);
      roll_x_in = rmte_pkg::XW'(pl[NBITS].r11);
    end else begin
      roll_y    = rmte_pkg::XW'(pl[NBITS].r21);
      roll_x_in = rmte_pkg::XW'(pl[NBITS].r22);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs[0][0] <= rmte_pkg::prerot(roll_y, roll_x_in, PI);
      cs[0][1] <= rmte_pkg::prerot(-rmte_pkg::XW'(pl[NBITS].r20),
                                   rmte_pkg::XW'(root_s[NBITS]), PI);
      cs[0][2] <= rmte_pkg::prerot(rmte_pkg::XW'(pl[NBITS].r10),
                                   rmte_pkg::XW'(pl[NBITS].r00), PI);
      lk[0]    <= lock_c;
    end
  end

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
    for (genvar l = 0; l < 3; l++) begin : g_lane
      rmte_cordic_cell #(.STAGE(j), .FRAC_BITS(FRAC_BITS)) u_cell (
        .clk   (clk),
        .en    (en),
        .c_in  (cs[j][l]),
        .c_out (cs[j+1][l])
      );
    end
    always_ff @(posedge clk) begin
      if (en) begin
        lk[j+1] <= lk[j];
      end
    end
  end

  // output register, yaw forced to zero under gimbal lock
  always_ff @(posedge clk) begin
    if (en) begin
      roll_x      <= rmte_pkg::sat_angle(cs[CORDIC_STAGES][0], 1'b0, PI);
      pitch_y     <= rmte_pkg::sat_angle(cs[CORDIC_STAGES][1], 1'b0, PI);
      yaw_z       <= rmte_pkg::sat_angle(cs[CORDIC_STAGES][2], lk[CORDIC_STAGES], PI);
      gimbal_lock <= lk[CORDIC_STAGES];
    end
  end

endmodule
`default_nettype wire
